FILE: rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, codes and helpers of the mode-banked register file.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned GPR_DEPTH  = 31;  // 16 user, 7 FIQ, 8 IRQ/SVC/ABT/UND
    localparam int unsigned SPSR_DEPTH = 5;
    localparam int unsigned SLOT_W     = $clog2(GPR_DEPTH);
    localparam int unsigned SPSR_W     = $clog2(SPSR_DEPTH);

    // Mode field of the status word
    localparam logic [3:0] MODE_USR = 4'd0;
    localparam logic [3:0] MODE_FIQ = 4'd1;
    localparam logic [3:0] MODE_IRQ = 4'd2;
    localparam logic [3:0] MODE_SVC = 4'd3;
    localparam logic [3:0] MODE_ABT = 4'd7;
    localparam logic [3:0] MODE_UND = 4'd11;
    localparam logic [3:0] MODE_SYS = 4'd15;

    // Base slots of the banked registers (FIQ r8-r14, then the r13/r14 pairs) in the flat register array
    localparam logic [SLOT_W-1:0] SLOT_FIQ_R8 = SLOT_W'(16);
    localparam logic [SLOT_W-1:0] SLOT_IRQ_SP = SLOT_W'(23);
    localparam logic [SLOT_W-1:0] SLOT_SVC_SP = SLOT_W'(25);
    localparam logic [SLOT_W-1:0] SLOT_ABT_SP = SLOT_W'(27);
    localparam logic [SLOT_W-1:0] SLOT_UND_SP = SLOT_W'(29);

    localparam logic [SPSR_W-1:0] SAVED_FIQ = SPSR_W'(0);
    localparam logic [SPSR_W-1:0] SAVED_IRQ = SPSR_W'(1);
    localparam logic [SPSR_W-1:0] SAVED_SVC = SPSR_W'(2);
    localparam logic [SPSR_W-1:0] SAVED_ABT = SPSR_W'(3);
    localparam logic [SPSR_W-1:0] SAVED_UND = SPSR_W'(4);

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    typedef enum logic [3:0] {
        CMD_READ      = 4'd0,
        CMD_WRITE     = 4'd1,
        CMD_ADD       = 4'd2,
        CMD_SUB       = 4'd3,
        CMD_READ_PSR  = 4'd4,
        CMD_WRITE_PSR = 4'd5,
        CMD_READ_SPSR = 4'd6,
        CMD_WRITE_SPSR= 4'd7,
        CMD_READ_PF   = 4'd8,
        CMD_WRITE_PF  = 4'd9,
        CMD_STOP      = 4'd10,
        CMD_RESTART   = 4'd11
    } t_cmd;

    // Result of the mode decode for one request
    typedef struct packed {
        logic              mode_ok;   // mode valid for register commands
        logic              spsr_ok;   // mode owns a saved status word
        logic [SLOT_W-1:0] slot;      // flat register slot
        logic [SPSR_W-1:0] spsr_sel;  // saved status entry
    } t_access;

    function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
        logic [DATA_W-1:0] m;
        case (size)
            SIZE_BYTE: m = DATA_W'(32'h0000_00FF);
            SIZE_HALF: m = DATA_W'(32'h0000_FFFF);
            default:   m = '1;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/brf_map.sv
// ----------------------------------------------------------------------------
// brf_map
// Mode decode: steers a register number to its bank slot and picks the
// saved status entry of the current mode.
// ----------------------------------------------------------------------------
module brf_map
    import brf_pkg::*;
(
    input  logic [3:0] i_mode,
    input  logic [3:0] i_reg_index,
    output t_access    o_access
);

    logic              is_fiq;
    logic              own_sp;
    logic [SLOT_W-1:0] sp_base;

    always_comb begin
        o_access = '0;
        is_fiq   = 1'b0;
        own_sp   = 1'b0;
        sp_base  = '0;
        unique case (i_mode) inside
            MODE_USR, MODE_SYS: begin
                o_access.mode_ok = 1'b1;
            end
            MODE_FIQ: begin
                o_access.mode_ok  = 1'b1;
                o_access.spsr_ok  = 1'b1;
                o_access.spsr_sel = SAVED_FIQ;
                is_fiq            = 1'b1;
            end
            MODE_IRQ: begin
                o_access.mode_ok  = 1'b1;
                o_access.spsr_ok  = 1'b1;
                o_access.spsr_sel = SAVED_IRQ;
                own_sp            = 1'b1;
                sp_base           = SLOT_IRQ_SP;
            end
            MODE_SVC: begin
                o_access.mode_ok  = 1'b1;
                o_access.spsr_ok  = 1'b1;
                o_access.spsr_sel = SAVED_SVC;
                own_sp            = 1'b1;
                sp_base           = SLOT_SVC_SP;
            end
            MODE_ABT: begin
                o_access.mode_ok  = 1'b1;
                o_access.spsr_ok  = 1'b1;
                o_access.spsr_sel = SAVED_ABT;
                own_sp            = 1'b1;
                sp_base           = SLOT_ABT_SP;
            end
            MODE_UND: begin
                o_access.mode_ok  = 1'b1;
                o_access.spsr_ok  = 1'b1;
                o_access.spsr_sel = SAVED_UND;
                own_sp            = 1'b1;
                sp_base           = SLOT_UND_SP;
            end
            default: begin
                o_access.mode_ok = 1'b0;
            end
        endcase

        // r0-r7 and r15 are never banked
        if (!i_reg_index[3] || i_reg_index == 4'd15) begin
            o_access.slot = SLOT_W'(i_reg_index);
        end else if (is_fiq) begin
            o_access.slot = SLOT_FIQ_R8 + SLOT_W'(i_reg_index[2:0]);
        end else if (i_reg_index < 4'd13 || !own_sp) begin
            o_access.slot = SLOT_W'(i_reg_index);
        end else begin
            o_access.slot = sp_base + SLOT_W'(i_reg_index == 4'd14);
        end
    end

endmodule

FILE: rtl/brf_state.sv
// ----------------------------------------------------------------------------
// brf_state
// Architectural storage and the combinational execute of one request, committed on i_exec.
// ----------------------------------------------------------------------------
module brf_state
    import brf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_exec,
    input  logic [3:0]        i_command,
    input  logic [1:0]        i_access_size,
    input  logic [DATA_W-1:0] i_value,
    input  t_access           i_access,
    output logic [3:0]        o_mode,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_error,
    output logic              o_running
);

    logic [DATA_W-1:0] r_gpr [GPR_DEPTH];
    logic [DATA_W-1:0] r_spsr [SPSR_DEPTH];
    logic [DATA_W-1:0] r_psr;
    logic [DATA_W-1:0] r_pf;
    logic              r_run;

    t_cmd              cmd;
    logic [DATA_W-1:0] gpr_q;
    logic [DATA_W-1:0] gpr_wdata;
    logic              gpr_we;
    logic              spsr_we;
    logic              n_run;

    assign cmd    = t_cmd'(i_command);
    assign gpr_q  = r_gpr[i_access.slot];
    assign o_mode = r_psr[3:0];

    always_comb begin
        o_read_data = '0;
        o_error     = 1'b0;
        gpr_we      = 1'b0;
        spsr_we     = 1'b0;
        gpr_wdata   = '0;
        n_run       = r_run;
        case (cmd) inside
            CMD_READ, CMD_WRITE, CMD_ADD, CMD_SUB: begin
                o_error = !i_access.mode_ok;
                gpr_we  = i_access.mode_ok && (cmd != CMD_READ);
                case (cmd)
                    CMD_READ:  o_read_data = i_access.mode_ok ?
                                             gpr_q & size_mask(i_access_size) : '0;
                    CMD_WRITE: gpr_wdata = i_value & size_mask(i_access_size);
                    CMD_ADD:   gpr_wdata = gpr_q + i_value;
                    default:   gpr_wdata = gpr_q - i_value;
                endcase
            end
            CMD_READ_PSR: o_read_data = r_psr;
            CMD_READ_SPSR: begin
                o_error     = !i_access.spsr_ok;
                o_read_data = i_access.spsr_ok ? r_spsr[i_access.spsr_sel] : '0;
            end
            CMD_WRITE_SPSR: begin
                o_error = !i_access.spsr_ok;
                spsr_we = i_access.spsr_ok;
            end
            CMD_READ_PF: o_read_data = r_pf;
            CMD_STOP:    n_run = 1'b0;
            CMD_RESTART: n_run = 1'b1;
            default: ;
        endcase
        o_running = n_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GPR_DEPTH; i++) r_gpr[i] <= '0;
            for (int i = 0; i < SPSR_DEPTH; i++) r_spsr[i] <= '0;
            r_psr <= '0;
            r_pf  <= '0;
            r_run <= 1'b0;
        end else if (i_exec) begin
            if (gpr_we) r_gpr[i_access.slot] <= gpr_wdata;
            if (spsr_we) r_spsr[i_access.spsr_sel] <= i_value;
            if (cmd == CMD_WRITE_PSR) r_psr <= i_value;
            if (cmd == CMD_WRITE_PF) r_pf <= i_value;
            r_run <= n_run;
        end
    end

endmodule

FILE: rtl/banked_register_file_top.sv
// ----------------------------------------------------------------------------
// banked_register_file_top
// Mode-banked 32-bit register file with status, saved status and prefetch.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_in_valid / o_in_stall carry one request (command,
//   register number, access size, value). A request is taken at a rising
//   edge with i_in_valid high and o_in_stall low.
//   Result channel: o_out_valid / i_out_stall carry one result per request
//   (read data, error flag, run flag), taken when o_out_valid is high and
//   i_out_stall is low.
//   Datapath: a request is captured in the input register, then decoded
//   against the current mode, executed on the register state and written
//   into the result register in one pass.
//   Throughput: one request per cycle while the result side is not stalled;
//   the state update and the result register load happen on the same edge,
//   so the next request sees it. Stall: while the result register is full
//   and stalled, the input stage holds and o_in_stall goes high once it is occupied.
//   Reset (synchronous, active low): all registers, status word, saved
//   status words, prefetch word and run flag clear to zero; both stages
//   empty.
// ----------------------------------------------------------------------------
module banked_register_file_top
    import brf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [3:0]        i_command,
    input  logic [3:0]        i_reg_index,
    input  logic [1:0]        i_access_size,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_error,
    output logic              o_running
);

    // Input register
    logic              r_s1_valid;
    logic [3:0]        r_command;
    logic [3:0]        r_reg_index;
    logic [1:0]        r_access_size;
    logic [DATA_W-1:0] r_value;

    // Result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data;
    logic              r_error;
    logic              r_running;

    logic              advance;
    logic [3:0]        mode;
    t_access           access;
    logic [DATA_W-1:0] exec_read_data;
    logic              exec_error;
    logic              exec_running;

    // Advance the input stage whenever the result register is free or drains
    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_command     <= i_command;
            r_reg_index   <= i_reg_index;
            r_access_size <= i_access_size;
            r_value       <= i_value;
        end
    end

    brf_map u_map (
        .i_mode      (mode),
        .i_reg_index (r_reg_index),
        .o_access    (access)
    );

    brf_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_exec        (advance),
        .i_command     (r_command),
        .i_access_size (r_access_size),
        .i_value       (r_value),
        .i_access      (access),
        .o_mode        (mode),
        .o_read_data   (exec_read_data),
        .o_error       (exec_error),
        .o_running     (exec_running)
    );

    // Load the result on advance, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data <= exec_read_data;
            r_error     <= exec_error;
            r_running   <= exec_running;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_error     = r_error;
    assign o_running   = r_running;

`ifndef NO_ASSERTIONS
    // An error result never carries read data
    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_read_data == '0)
        else $error("error result carries nonzero read data");

    // Both stages come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_s1_valid)
        else $error("pipeline not empty after reset");

    // A held request moves into an empty result register at once
    a_fill_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !o_out_valid |=> o_out_valid)
        else $error("request not advanced into empty result register");

    // Input stall only when the result side blocks
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");
`endif

endmodule
